/* rtl/core/c_source_bracket_checker_top_macros.svh */
// Assertion macros for the bracket checker stack unit.
`ifndef C_SOURCE_BRACKET_CHECKER_TOP_MACROS_SVH
`define C_SOURCE_BRACKET_CHECKER_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CBC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that implies a consequence at the next clock edge.
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cbc_pkg.sv */
package cbc_pkg;

  // Default number of openers that the stack can hold.
  localparam int unsigned STACK_DEPTH_DEF = 256;

  // Depth of the event queue between the lexer and the stack unit.
  localparam int unsigned EV_FIFO_DEPTH = 2;

  // Character codes that the lexer and the stack unit recognize.
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;

  localparam logic [15:0] LINE_FIRST = 16'd1;
  localparam logic [15:0] LINE_MAX   = 16'hFFFF;

  // Result status, also used as the sticky error kind.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNMATCHED = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  // Bracket event passed from the lexer to the stack unit.
  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_OPEN_PAREN  = 3'd1,
    EV_OPEN_BRACE  = 3'd2,
    EV_CLOSE_PAREN = 3'd3,
    EV_CLOSE_BRACE = 3'd4
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic        last;
    logic [15:0] line;
  } ev_t;

  // One stack entry: the kind of opener and the line it was on.
  typedef struct packed {
    logic        is_brace;
    logic [15:0] line;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Words on the two channels.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  bracket_code;
    logic [15:0] line_number;
  } out_word_t;

endpackage

/* rtl/core/c_source_bracket_checker_top.sv */
// Channel | Direction | Handshake                  | Word
// input   | in        | in_valid_i / in_stall_o    | in_word_i  (text_byte, end_of_text)
// result  | out       | out_valid_o / out_stall_i  | out_word_o (status, bracket_code, line_number)
//
// One text byte is taken per cycle unless the event queue is full; each byte does at most one
// push or pop in the stack unit. The top of stack sits in a register and the entry below it is
// prefetched from the RAM, with a write bypass, so a pop can follow a push in the next cycle.
// After the last byte is taken, its event passes through the event queue into the result
// register, which it enters once that register is free.
// Reset needs no clearing pass; only entries below the stack pointer are ever used.
// The input stalls only when the two-entry event queue is full: a final event waits there
// while the previous result is held by out_stall_i, and one more event follows it.
module c_source_bracket_checker_top #(
  parameter int unsigned STACK_DEPTH = cbc_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbc_pkg::in_word_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbc_pkg::out_word_t out_word_o
);

  import cbc_pkg::*;

  logic ev_push, ev_ready, ev_valid, ev_pop;
  ev_t  ev_in, ev_head;

  // Front end: lexer that turns bytes into bracket events.
  cbc_lexer u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .ev_valid_o (ev_push),
    .ev_ready_i (ev_ready),
    .ev_o       (ev_in)
  );

  // Short queue between the lexer and the stack unit.
  cbc_event_fifo u_event_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (ev_push),
    .ready_o   (ev_ready),
    .push_ev_i (ev_in),
    .valid_o   (ev_valid),
    .pop_i     (ev_pop),
    .head_o    (ev_head)
  );

  // Back end: opener stack, sticky error and result register.
  cbc_stack_unit #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_pop_o    (ev_pop),
    .ev_i        (ev_head),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/core/cbc_ram.sv */
module cbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cbc_lexer.sv */
module cbc_lexer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cbc_pkg::in_word_t in_word_i,
  output logic             ev_valid_o,
  input  logic             ev_ready_i,
  output cbc_pkg::ev_t      ev_o
);

  import cbc_pkg::*;

  typedef enum logic [2:0] {
    MODE_CODE,
    MODE_LINE,
    MODE_BLOCK,
    MODE_CHAR,
    MODE_STR
  } mode_e;

  mode_e       mode_q, mode_d;
  logic        slash_q, slash_d;
  logic        star_q, star_d;
  logic [15:0] line_q, line_d;
  ev_kind_e    kind;
  logic        accept;
  logic [7:0]  b;

  assign b          = in_word_i.text_byte;
  assign accept     = in_valid_i && ev_ready_i;
  assign in_stall_o = !ev_ready_i;

  // Classify the byte and advance the comment and literal tracking.
  always_comb begin
    logic treat;
    mode_d = mode_q;
    slash_d = slash_q;
    star_d = star_q;
    line_d = line_q;
    kind = EV_NONE;
    treat = 1'b0;
    case (mode_q)
      MODE_LINE: begin
        if (b == CHAR_LF) mode_d = MODE_CODE;
      end
      MODE_BLOCK: begin
        if (star_q && b == CHAR_SLASH) begin
          mode_d = MODE_CODE;
          star_d = 1'b0;
        end else begin
          star_d = (b == CHAR_STAR);
        end
      end
      MODE_CHAR: begin
        if (b == CHAR_SQUOTE) mode_d = MODE_CODE;
      end
      MODE_STR: begin
        if (b == CHAR_DQUOTE) mode_d = MODE_CODE;
      end
      default: begin
        mode_d = MODE_CODE;
        treat = 1'b1;
        if (slash_q) begin
          slash_d = 1'b0;
          if (b == CHAR_SLASH) begin
            mode_d = MODE_LINE;
            treat = 1'b0;
          end else if (b == CHAR_STAR) begin
            mode_d = MODE_BLOCK;
            star_d = 1'b0;
            treat = 1'b0;
          end
        end
      end
    endcase
    // Plain code: comment starts, literal starts and brackets.
    if (treat) begin
      case (b)
        CHAR_SLASH:  slash_d = 1'b1;
        CHAR_SQUOTE: mode_d = MODE_CHAR;
        CHAR_DQUOTE: mode_d = MODE_STR;
        CHAR_LPAREN: kind = EV_OPEN_PAREN;
        CHAR_LBRACE: kind = EV_OPEN_BRACE;
        CHAR_RPAREN: kind = EV_CLOSE_PAREN;
        CHAR_RBRACE: kind = EV_CLOSE_BRACE;
        default: ;
      endcase
    end
    if (b == CHAR_LF && line_q != LINE_MAX) begin
      line_d = line_q + 16'd1;
    end
    // The last byte of a text returns the lexer to its starting state.
    if (in_word_i.end_of_text) begin
      mode_d = MODE_CODE;
      slash_d = 1'b0;
      star_d = 1'b0;
      line_d = LINE_FIRST;
    end
  end

  // Only brackets and the end of text are of interest downstream.
  assign ev_valid_o = accept && (kind != EV_NONE || in_word_i.end_of_text);
  assign ev_o.kind  = kind;
  assign ev_o.last  = in_word_i.end_of_text;
  assign ev_o.line  = line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CODE;
      slash_q <= 1'b0;
      star_q <= 1'b0;
      line_q <= LINE_FIRST;
    end else if (accept) begin
      mode_q <= mode_d;
      slash_q <= slash_d;
      star_q <= star_d;
      line_q <= line_d;
    end
  end

endmodule

/* rtl/core/cbc_event_fifo.sv */
module cbc_event_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        ready_o,
  input  cbc_pkg::ev_t push_ev_i,
  output logic        valid_o,
  input  logic        pop_i,
  output cbc_pkg::ev_t head_o
);

  import cbc_pkg::*;

  localparam int unsigned PW = (EV_FIFO_DEPTH > 1) ? $clog2(EV_FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(EV_FIFO_DEPTH + 1);

  ev_t           slot_q [EV_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign ready_o = (count_q != CW'(EV_FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Event payload storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_ev_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(EV_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(EV_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/cbc_stack_unit.sv */
module cbc_stack_unit #(
  parameter int unsigned STACK_DEPTH = cbc_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_valid_i,
  output logic              ev_pop_o,
  input  cbc_pkg::ev_t       ev_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbc_pkg::out_word_t out_word_o
);

  import cbc_pkg::*;

  `include "c_source_bracket_checker_top_macros.svh"

  localparam int unsigned IW = $clog2(STACK_DEPTH);
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);

  logic [SW-1:0] sp_q, sp_d;
  entry_t        top_q, top_d;
  status_e       err_q, err_d;
  logic [7:0]    ecode_q, ecode_d;
  logic [15:0]   eline_q, eline_d;
  logic          byp_q;
  entry_t        byp_data_q;
  entry_t        second;
  logic          out_valid_q;
  out_word_t     out_word_q, result;
  logic          take;
  logic          ram_we;
  logic [SW-1:0] sp_m1, sp_m2;
  logic [ENTRY_W-1:0] ram_rdata;

  // A final event needs a free output register; other events never wait.
  assign take     = ev_valid_i && (!ev_i.last || !out_valid_q || !out_stall_i);
  assign ev_pop_o = take;

  // The entry below the top comes from the RAM or from last cycle's write.
  assign second = byp_q ? byp_data_q : entry_t'(ram_rdata);

  // Stack and error update for one event.
  always_comb begin
    logic push_req;
    logic push_brace;
    logic want_brace;
    sp_d = sp_q;
    top_d = top_q;
    err_d = err_q;
    ecode_d = ecode_q;
    eline_d = eline_q;
    ram_we = 1'b0;
    push_req = 1'b0;
    push_brace = 1'b0;
    want_brace = (ev_i.kind == EV_CLOSE_BRACE);
    if (take && err_q == STATUS_OK) begin
      case (ev_i.kind)
        EV_OPEN_PAREN: begin
          push_req = 1'b1;
        end
        EV_OPEN_BRACE: begin
          if (sp_q != '0 && !top_q.is_brace) begin
            err_d = STATUS_UNMATCHED;
            ecode_d = CHAR_LPAREN;
            eline_d = top_q.line;
          end else begin
            push_req = 1'b1;
            push_brace = 1'b1;
          end
        end
        EV_CLOSE_PAREN, EV_CLOSE_BRACE: begin
          if (sp_q == '0 || top_q.is_brace != want_brace) begin
            err_d = STATUS_UNMATCHED;
            ecode_d = want_brace ? CHAR_RBRACE : CHAR_RPAREN;
            eline_d = ev_i.line;
          end else begin
            sp_d = sp_q - SW'(1);
            top_d = second;
          end
        end
        default: ;
      endcase
    end
    // A push spills the old top into the RAM and keeps the new one here.
    if (push_req) begin
      if (sp_q == SW'(STACK_DEPTH)) begin
        err_d = STATUS_OVERFLOW;
        ecode_d = push_brace ? CHAR_LBRACE : CHAR_LPAREN;
        eline_d = ev_i.line;
      end else begin
        ram_we = (sp_q != '0);
        top_d.is_brace = push_brace;
        top_d.line = ev_i.line;
        sp_d = sp_q + SW'(1);
      end
    end
  end

  assign sp_m1 = sp_q - SW'(1);
  assign sp_m2 = sp_d - SW'(2);

  // Report built from the state after the final event.
  always_comb begin
    if (err_d != STATUS_OK) begin
      result.status = err_d;
      result.bracket_code = ecode_d;
      result.line_number = eline_d;
    end else if (sp_d != '0) begin
      result.status = STATUS_UNMATCHED;
      result.bracket_code = top_d.is_brace ? CHAR_LBRACE : CHAR_LPAREN;
      result.line_number = top_d.line;
    end else begin
      result.status = STATUS_OK;
      result.bracket_code = '0;
      result.line_number = '0;
    end
  end

  cbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sp_m1[IW-1:0]),
    .wdata_i (top_q),
    .raddr_i (sp_m2[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Payload registers for the top entry, the read bypass and the result word.
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    byp_data_q <= top_q;
    if (take && ev_i.last) begin
      out_word_q <= result;
    end
  end

  // Control state; the final event of a text clears the stack and error.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      err_q <= STATUS_OK;
      ecode_q <= '0;
      eline_q <= '0;
      byp_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      byp_q <= ram_we;
      if (take && ev_i.last) begin
        sp_q <= '0;
        err_q <= STATUS_OK;
        ecode_q <= '0;
        eline_q <= '0;
        out_valid_q <= 1'b1;
      end else begin
        sp_q <= sp_d;
        err_q <= err_d;
        ecode_q <= ecode_d;
        eline_q <= eline_d;
        if (!out_stall_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `CBC_ASSERT(a_sp_in_range, clk_i, rst_ni, sp_q <= SW'(STACK_DEPTH), "stack pointer beyond depth")
  `CBC_ASSERT(a_overflow_full, clk_i, rst_ni,
    err_q != STATUS_OVERFLOW || sp_q == SW'(STACK_DEPTH), "overflow with room on stack")
  `CBC_ASSERT_NEXT(a_error_sticks, clk_i, rst_ni, err_q != STATUS_OK && !(take && ev_i.last),
    err_q == $past(err_q) && sp_q == $past(sp_q), "sticky error or stack changed")
  `CBC_ASSERT_NEXT(a_close_on_empty, clk_i, rst_ni,
    take && !ev_i.last && err_q == STATUS_OK && sp_q == '0 &&
    (ev_i.kind == EV_CLOSE_PAREN || ev_i.kind == EV_CLOSE_BRACE),
    err_q == STATUS_UNMATCHED, "closer on empty stack not flagged")

endmodule

/* bench/tb_c_source_bracket_checker_top.sv */
`timescale 1ns / 100ps

module tb_c_source_bracket_checker_top;
  import cbc_pkg::*;

  localparam int unsigned STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TOTAL_ITEMS = 1500;
  localparam int unsigned MAX_IDLE = 12;

  // Scanner modes of the predictor.
  typedef enum logic [2:0] {
    LEX_CODE,
    LEX_LINE,
    LEX_BLOCK,
    LEX_CHAR,
    LEX_STR
  } lex_mode_e;

  // Tracks the text scanner and opener stack, and holds the expected results.
  class bracket_scoreboard;
    lex_mode_e   mode;
    bit          slash_held;
    bit          star_held;
    logic [15:0] cur_line;
    entry_t      openers[];
    int unsigned depth;
    int unsigned open_count;
    status_e     err_kind;
    logic [7:0]  err_code;
    logic [15:0] err_line;
    out_word_t   due_q[$];
    int unsigned fail_count;

    function new(int unsigned stack_size);
      depth = stack_size;
      openers = new[stack_size];
      fail_count = 0;
      clear();
    endfunction

    function void clear();
      mode = LEX_CODE;
      slash_held = 1'b0;
      star_held = 1'b0;
      cur_line = LINE_FIRST;
      open_count = 0;
      err_kind = STATUS_OK;
      err_code = '0;
      err_line = '0;
    endfunction

    function void record_error(status_e kind, logic [7:0] code, logic [15:0] line);
      err_kind = kind;
      err_code = code;
      err_line = line;
    endfunction

    function void push_opener(bit brace);
      if (open_count >= depth) begin
        record_error(STATUS_OVERFLOW, brace ? CHAR_LBRACE : CHAR_LPAREN, cur_line);
        return;
      end
      openers[open_count].is_brace = brace;
      openers[open_count].line = cur_line;
      open_count++;
    endfunction

    // Bracket rules apply only until the first error.
    function void take_bracket(logic [7:0] b);
      bit want_brace;
      if (err_kind != STATUS_OK) return;
      if (b == CHAR_LPAREN) begin
        push_opener(1'b0);
      end else if (b == CHAR_LBRACE) begin
        if (open_count > 0 && !openers[open_count - 1].is_brace) begin
          record_error(STATUS_UNMATCHED, CHAR_LPAREN, openers[open_count - 1].line);
        end else begin
          push_opener(1'b1);
        end
      end else begin
        want_brace = (b == CHAR_RBRACE);
        if (open_count == 0 || openers[open_count - 1].is_brace != want_brace) begin
          record_error(STATUS_UNMATCHED, b, cur_line);
        end else begin
          open_count--;
        end
      end
    endfunction

    function void take_code(logic [7:0] b);
      case (b)
        CHAR_SLASH: slash_held = 1'b1;
        CHAR_SQUOTE: mode = LEX_CHAR;
        CHAR_DQUOTE: mode = LEX_STR;
        CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACE, CHAR_RBRACE: take_bracket(b);
        default: ;
      endcase
    endfunction

    // Called for every word accepted on the input channel.
    function void note_word(in_word_t w);
      logic [7:0] b;
      out_word_t  res;
      b = w.text_byte;
      case (mode)
        LEX_LINE: if (b == CHAR_LF) mode = LEX_CODE;
        LEX_BLOCK: begin
          if (star_held && b == CHAR_SLASH) begin
            mode = LEX_CODE;
            star_held = 1'b0;
          end else begin
            star_held = (b == CHAR_STAR);
          end
        end
        LEX_CHAR: if (b == CHAR_SQUOTE) mode = LEX_CODE;
        LEX_STR: if (b == CHAR_DQUOTE) mode = LEX_CODE;
        default: begin
          if (slash_held && b == CHAR_SLASH) begin
            slash_held = 1'b0;
            mode = LEX_LINE;
          end else if (slash_held && b == CHAR_STAR) begin
            slash_held = 1'b0;
            mode = LEX_BLOCK;
            star_held = 1'b0;
          end else begin
            slash_held = 1'b0;
            take_code(b);
          end
        end
      endcase
      if (b == CHAR_LF && cur_line != LINE_MAX) cur_line++;
      if (!w.end_of_text) return;

      // The final byte yields one result and restarts the scan.
      res.status = STATUS_OK;
      res.bracket_code = '0;
      res.line_number = '0;
      if (err_kind != STATUS_OK) begin
        res.status = err_kind;
        res.bracket_code = err_code;
        res.line_number = err_line;
      end else if (open_count > 0) begin
        res.status = STATUS_UNMATCHED;
        res.bracket_code = openers[open_count - 1].is_brace ? CHAR_LBRACE : CHAR_LPAREN;
        res.line_number = openers[open_count - 1].line;
      end
      due_q.push_back(res);
      clear();
    endfunction

    // Called for every word accepted on the result channel.
    function void check_result(out_word_t got);
      out_word_t want;
      if (due_q.size() == 0) begin
        $error("result word with no expectation: status %0d code %0h line %0d",
               got.status, got.bracket_code, got.line_number);
        fail_count++;
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.bracket_code !== want.bracket_code) begin
        $error("bracket_code: expected %0h, got %0h", want.bracket_code, got.bracket_code);
        fail_count++;
      end
      if (got.line_number !== want.line_number) begin
        $error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;

  bracket_scoreboard sb = new(STACK_DEPTH);

  logic [7:0]  text_q[$];
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned rx_wait = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;

  c_source_bracket_checker_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** c_source_bracket_checker_top: FAILED **");
      $finish;
    end
  end

  // Result receiver: a drawn stall per word, plus the long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        rx_wait = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (out_valid_o && rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || (rx_wait > 0);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
  end

  // Offer one word after a drawn gap and hold it until it is taken.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
    words_sent++;
  endtask

  // Send the collected text, marking its final byte.
  task automatic send_text();
    in_word_t w;
    for (int i = 0; i < text_q.size(); i++) begin
      w.text_byte = text_q[i];
      w.end_of_text = (i == text_q.size() - 1);
      send_word(w);
    end
    text_q.delete();
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  task automatic send_run(logic [7:0] b, int unsigned count);
    repeat (count) text_q.push_back(b);
  endtask

  function automatic logic [7:0] byte_except(logic [7:0] excl);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == excl);
    return b;
  endfunction

  // Mostly the characters that the scanner reacts to.
  function automatic logic [7:0] lexer_char();
    case ($urandom_range(0, 9))
      0: return CHAR_LPAREN;
      1: return CHAR_RPAREN;
      2: return CHAR_LBRACE;
      3: return CHAR_RBRACE;
      4: return CHAR_SLASH;
      5: return CHAR_STAR;
      6: return CHAR_SQUOTE;
      7: return CHAR_DQUOTE;
      8: return CHAR_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds a plausible C fragment with random content and sends it.
  task automatic send_code_text();
    bit          braces[$];
    int unsigned tokens;
    int unsigned open_pct;
    int unsigned pick;
    int unsigned fill;
    tokens = $urandom_range(1, 30);
    open_pct = $urandom_range(15, 45);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      fill = $urandom_range(0, 6);
      if (pick < open_pct) begin
        // Braces go under braces; a rare brace inside parentheses is an error.
        if ((braces.size() == 0 || braces[$]) && $urandom_range(0, 1)) begin
          braces.push_back(1'b1);
          text_q.push_back(CHAR_LBRACE);
        end else if ($urandom_range(0, 30) == 0) begin
          text_q.push_back(CHAR_LBRACE);
        end else begin
          braces.push_back(1'b0);
          text_q.push_back(CHAR_LPAREN);
        end
      end else if (pick < open_pct + 25) begin
        if (braces.size() > 0) begin
          text_q.push_back(braces.pop_back() ? CHAR_RBRACE : CHAR_RPAREN);
        end else begin
          text_q.push_back(CHAR_LF);
        end
      end else if (pick < open_pct + 32) begin
        text_q.push_back(CHAR_LF);
      end else if (pick < open_pct + 37) begin
        text_q.push_back(CHAR_SLASH);
        text_q.push_back(CHAR_SLASH);
        repeat (fill) text_q.push_back(byte_except(CHAR_LF));
        text_q.push_back(CHAR_LF);
      end else if (pick < open_pct + 42) begin
        text_q.push_back(CHAR_SLASH);
        text_q.push_back(CHAR_STAR);
        repeat (fill) text_q.push_back(lexer_char());
        text_q.push_back(CHAR_STAR);
        text_q.push_back(CHAR_SLASH);
      end else if (pick < open_pct + 46) begin
        text_q.push_back(CHAR_DQUOTE);
        repeat (fill) text_q.push_back(byte_except(CHAR_DQUOTE));
        text_q.push_back(CHAR_DQUOTE);
      end else if (pick < open_pct + 49) begin
        text_q.push_back(CHAR_SQUOTE);
        text_q.push_back(byte_except(CHAR_SQUOTE));
        text_q.push_back(CHAR_SQUOTE);
      end else if (pick < open_pct + 51) begin
        text_q.push_back($urandom_range(0, 1) ? CHAR_RBRACE : CHAR_RPAREN);
      end else if (pick < open_pct + 54) begin
        text_q.push_back(CHAR_SLASH);
        text_q.push_back(lexer_char());
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // Most fragments close what they opened.
    if ($urandom_range(0, 99) < 85) begin
      while (braces.size() > 0) text_q.push_back(braces.pop_back() ? CHAR_RBRACE : CHAR_RPAREN);
    end
    send_text();
  endtask

  task automatic send_noise_text();
    repeat ($urandom_range(1, 20)) begin
      text_q.push_back($urandom_range(0, 1) ? lexer_char() : 8'($urandom_range(0, 255)));
    end
    send_text();
  endtask

  // Main sequence.
  initial begin
    in_word_t w;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed texts: matched pair, brace under a parenthesis, wrong closer,
    // block comment whose opening star does not close it, line comment,
    // quotes and a dropped slash.
    send_str("()");
    send_str("(\n{");
    send_str("{)");
    send_str("/*/(*/}");
    send_str("//(\n)");
    send_str("'('\"{\"/(");

    // Hold the results back while single-byte texts keep arriving.
    tx_idle_on = 1'b0;
    hold_left = 200;
    for (int i = 0; i < 30; i++) begin
      w.text_byte = (i % 2) ? CHAR_LBRACE : 8'($urandom_range(0, 255));
      w.end_of_text = 1'b1;
      send_word(w);
    end

    // Stack filled exactly, then overflow by either opener.
    rx_idle_on = 1'b0;
    send_run(CHAR_LPAREN, STACK_DEPTH);
    send_run(CHAR_RPAREN, STACK_DEPTH);
    send_text();
    send_run(CHAR_LPAREN, STACK_DEPTH + 1);
    send_text();
    send_run(CHAR_LBRACE, STACK_DEPTH);
    send_run(CHAR_LF, 3);
    send_run(CHAR_LBRACE, 1);
    send_text();

    // Random texts, mostly well-formed code, until the item count is reached.
    while (words_sent < TOTAL_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 4) != 0);
      rx_idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) != 0) send_code_text();
      else send_noise_text();
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then allow for the pipeline latency.
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.due_q.size() == 0) begin
      $display("** c_source_bracket_checker_top: PASSED **");
    end else begin
      $display("** c_source_bracket_checker_top: FAILED **");
    end
    $finish;
  end

endmodule

/* c_source_bracket_checker_top.f */
+incdir+rtl/core
rtl/core/cbc_pkg.sv
rtl/core/cbc_ram.sv
rtl/core/cbc_lexer.sv
rtl/core/cbc_event_fifo.sv
rtl/core/cbc_stack_unit.sv
rtl/core/c_source_bracket_checker_top.sv
bench/tb_c_source_bracket_checker_top.sv
